[rtl/q4_block_dot_row_accumulator_unit_macros.svh]
// Assertion helpers for the row accumulator.
`ifndef Q4_BLOCK_DOT_ROW_ACCUMULATOR_UNIT_MACROS_SVH
`define Q4_BLOCK_DOT_ROW_ACCUMULATOR_UNIT_MACROS_SVH

// same-cycle implication
`define Q4BD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define Q4BD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/q4bd_pkg.sv]
package q4bd_pkg;

   localparam int FloatW = 32;
   localparam int DotW   = 17;
   localparam int PsumW  = 15;
   localparam int QDepth = 4;
   localparam int QPtrW  = $clog2(QDepth);

   localparam logic [31:0] CanonNan = 32'h7FC0_0000;

   typedef struct packed {
      logic [FloatW-1:0]      scale;
      logic signed [DotW-1:0] dot;
      logic                   last;
   } qent_type;

   typedef struct packed {
      logic idle;
      logic emit;
   } bstat_type;

endpackage

[rtl/q4bd_front.sv]
module q4bd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [399:0]        req_tdata,
   input  logic                req_tlast,
   output logic                push_valid,
   output q4bd_pkg::qent_type  push_data,
   input  logic                push_ready
);

   function automatic logic [3:0] lzc10(input logic [9:0] x);
      logic [3:0] n;
      begin
         n = 4'd10;
         for (int i = 0; i < 10; i++) begin
            if (x[i]) n = 4'(9 - i);
         end
         return n;
      end
   endfunction

   logic                           v1_ff, v1_in, v2_ff, v2_in;
   logic signed [q4bd_pkg::PsumW-1:0] psum_ff [4];
   logic signed [q4bd_pkg::PsumW-1:0] psum_in [4];
   logic [31:0]                    scale1_ff, scale1_in;
   logic                           last1_ff;
   q4bd_pkg::qent_type             ent2_ff, ent2_in;
   logic                           adv;

   assign adv        = !v2_ff || push_ready;
   assign req_tready = adv;
   assign push_valid = v2_ff;
   assign push_data  = ent2_ff;

   always_comb begin
      logic [127:0] wts;
      logic [255:0] acts;
      logic [7:0]   b;
      logic signed [11:0] lo, hi, al, ah;
      logic signed [q4bd_pkg::PsumW-1:0] acc;
      logic [15:0]  h;
      logic [3:0]   sh;
      logic [9:0]   mn;
      wts  = req_tdata[143:16];
      acts = req_tdata[399:144];
      for (int g = 0; g < 4; g++) begin
         acc = '0;
         for (int k = 0; k < 4; k++) begin
            b  = wts[8*(4*g+k) +: 8];
            lo = {{8{~b[3]}}, ~b[3], b[2:0]};
            hi = {{8{~b[7]}}, ~b[7], b[6:4]};
            al = {{4{acts[16*(4*g+k)+7]}}, acts[16*(4*g+k) +: 8]};
            ah = {{4{acts[16*(4*g+k)+15]}}, acts[16*(4*g+k)+8 +: 8]};
            acc = acc + q4bd_pkg::PsumW'(lo * al) + q4bd_pkg::PsumW'(hi * ah);
         end
         psum_in[g] = acc;
      end
      h  = req_tdata[15:0];
      sh = lzc10(h[9:0]) + 4'd1;
      mn = 10'(h[9:0] << sh);
      if (h[14:10] == 5'd0) begin
         if (h[9:0] == 10'd0) scale1_in = {h[15], 31'd0};
         else scale1_in = {h[15], 8'(8'd113 - {4'd0, sh}), mn, 13'd0};
      end else if (h[14:10] == 5'h1F) begin
         scale1_in = {h[15], 8'hFF, h[9:0], 13'd0};
      end else begin
         scale1_in = {h[15], 8'({3'd0, h[14:10]} + 8'd112), h[9:0], 13'd0};
      end
   end

   always_comb begin
      v1_in = v1_ff;
      v2_in = v2_ff;
      ent2_in = ent2_ff;
      if (adv) begin
         v1_in = req_tvalid;
         v2_in = v1_ff;
         ent2_in.scale = scale1_ff;
         ent2_in.last  = last1_ff;
         ent2_in.dot   = q4bd_pkg::DotW'(psum_ff[0]) + q4bd_pkg::DotW'(psum_ff[1])
                       + q4bd_pkg::DotW'(psum_ff[2]) + q4bd_pkg::DotW'(psum_ff[3]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
      ent2_ff <= ent2_in;
      if (adv) begin
         psum_ff   <= psum_in;
         scale1_ff <= scale1_in;
         last1_ff  <= req_tlast;
      end
   end

endmodule

[rtl/q4bd_queue.sv]
module q4bd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  q4bd_pkg::qent_type  push_data,
   output logic                push_ready,
   output logic                pop_valid,
   output q4bd_pkg::qent_type  pop_data,
   input  logic                pop_ready
);

   q4bd_pkg::qent_type                mem_ff [q4bd_pkg::QDepth];
   logic [q4bd_pkg::QPtrW-1:0]        wr_ff, wr_in, rd_ff, rd_in;
   logic [q4bd_pkg::QPtrW:0]          cnt_ff, cnt_in;
   logic                              push, pop;

   assign push_ready = cnt_ff != (q4bd_pkg::QPtrW+1)'(q4bd_pkg::QDepth);
   assign pop_valid  = cnt_ff != '0;
   assign pop_data   = mem_ff[rd_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (q4bd_pkg::QPtrW+1)'(push) - (q4bd_pkg::QPtrW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= push_data;
   end

endmodule

[rtl/q4bd_back.sv]
module q4bd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   input  q4bd_pkg::qent_type  pop_data,
   output logic                pop_ready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [31:0]         rsp_tdata,
   output q4bd_pkg::bstat_type status
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_MUL   = 4'd1;
   localparam logic [3:0] S_TNORM = 4'd2;
   localparam logic [3:0] S_TRND  = 4'd3;
   localparam logic [3:0] S_ALIGN = 4'd4;
   localparam logic [3:0] S_ADD   = 4'd5;
   localparam logic [3:0] S_NORM  = 4'd6;
   localparam logic [3:0] S_RND   = 4'd7;
   localparam logic [3:0] S_DONE  = 4'd8;

   localparam logic [1:0] K_FIN  = 2'd0;
   localparam logic [1:0] K_ZERO = 2'd1;
   localparam logic [1:0] K_INF  = 2'd2;
   localparam logic [1:0] K_NAN  = 2'd3;

   function automatic logic [4:0] lzc27(input logic [26:0] x);
      logic [4:0] n;
      begin
         n = 5'd27;
         for (int i = 0; i < 27; i++) begin
            if (x[i]) n = 5'(26 - i);
         end
         return n;
      end
   endfunction

   function automatic logic [31:0] round_pack(input logic s, input logic [8:0] e,
                                              input logic [26:0] n);
      logic        up;
      logic [24:0] r;
      logic [8:0]  ef;
      logic [22:0] m;
      logic [31:0] res;
      begin
         up = n[2] & (n[3] | n[1] | n[0]);
         r  = {1'b0, 1'b1, n[25:3]} + 25'(up);
         ef = e + 9'(r[24]);
         m  = r[24] ? 23'd0 : r[22:0];
         if (ef >= 9'd255) res = {s, 8'hFF, 23'd0};
         else res = {s, ef[7:0], m};
         return res;
      end
   endfunction

   function automatic logic [1:0] fkind(input logic [31:0] f);
      logic [1:0] k;
      begin
         if (f[30:23] == 8'hFF) k = (f[22:0] != 23'd0) ? K_NAN : K_INF;
         else if (f[30:23] == 8'd0) k = K_ZERO;
         else k = K_FIN;
         return k;
      end
   endfunction

   logic [3:0]          state_ff, state_in;
   q4bd_pkg::qent_type  ent_ff, ent_in;
   logic [31:0]         run_ff, run_in;
   logic [26:0]         prod_ff, prod_in;
   logic [26:0]         norm_ff, norm_in;
   logic [26:0]         siga_ff, siga_in, sigb_ff, sigb_in;
   logic [27:0]         sum_ff, sum_in;
   logic [8:0]          exp_ff, exp_in;
   logic                sign_ff, sign_in;
   logic                sub_ff, sub_in;
   logic                zero_ff, zero_in;
   logic [1:0]          kind_ff, kind_in;
   logic [31:0]         term_ff, term_in;
   logic [31:0]         res_ff, res_in;
   logic                rv_ff, rv_in;
   logic [31:0]         rd_ff, rd_in;
   logic                emit;

   assign pop_ready   = state_ff == S_IDLE;
   assign rsp_tvalid  = rv_ff;
   assign rsp_tdata   = rd_ff;
   assign status.idle = state_ff == S_IDLE;
   assign status.emit = emit;

   always_comb begin
      logic [7:0]  sexp;
      logic [15:0] absdot;
      logic [4:0]  lz;
      logic [1:0]  tk, rk;
      logic [31:0] a, b;
      logic [7:0]  d;
      logic [26:0] eb, sh, mask;
      state_in = state_ff;
      ent_in   = ent_ff;
      run_in   = run_ff;
      prod_in  = prod_ff;
      norm_in  = norm_ff;
      siga_in  = siga_ff;
      sigb_in  = sigb_ff;
      sum_in   = sum_ff;
      exp_in   = exp_ff;
      sign_in  = sign_ff;
      sub_in   = sub_ff;
      zero_in  = zero_ff;
      kind_in  = kind_ff;
      term_in  = term_ff;
      res_in   = res_ff;
      rv_in    = rv_ff && !rsp_tready;
      rd_in    = rd_ff;
      emit     = 1'b0;
      sexp     = ent_ff.scale[30:23];
      absdot   = ent_ff.dot[16] ? 16'(-ent_ff.dot) : ent_ff.dot[15:0];
      unique case (state_ff)
         S_IDLE: begin
            if (pop_valid) begin
               ent_in   = pop_data;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            sign_in = ent_ff.scale[31] ^ ent_ff.dot[16];
            if (sexp == 8'hFF) begin
               kind_in = (ent_ff.scale[22:0] != 23'd0 || absdot == 16'd0) ? K_NAN : K_INF;
            end else if (sexp == 8'd0 || absdot == 16'd0) begin
               kind_in = K_ZERO;
            end else begin
               kind_in = K_FIN;
            end
            prod_in  = 27'({1'b1, ent_ff.scale[22:13]}) * 27'(absdot);
            exp_in   = {1'b0, sexp} + 9'd10;
            state_in = S_TNORM;
         end
         S_TNORM: begin
            lz       = lzc27(prod_ff);
            norm_in  = prod_ff << lz;
            exp_in   = exp_ff - {4'd0, lz};
            state_in = S_TRND;
         end
         S_TRND: begin
            unique case (kind_ff)
               K_NAN:   term_in = q4bd_pkg::CanonNan;
               K_INF:   term_in = {sign_ff, 8'hFF, 23'd0};
               K_ZERO:  term_in = {sign_ff, 31'd0};
               default: term_in = round_pack(sign_ff, exp_ff, norm_ff);
            endcase
            state_in = S_ALIGN;
         end
         S_ALIGN: begin
            tk = fkind(term_ff);
            rk = fkind(run_ff);
            state_in = S_DONE;
            if (tk == K_NAN || rk == K_NAN) begin
               res_in = q4bd_pkg::CanonNan;
            end else if (tk == K_INF && rk == K_INF) begin
               res_in = (term_ff[31] != run_ff[31]) ? q4bd_pkg::CanonNan : term_ff;
            end else if (tk == K_INF) begin
               res_in = term_ff;
            end else if (rk == K_INF) begin
               res_in = run_ff;
            end else if (tk == K_ZERO && rk == K_ZERO) begin
               res_in = {term_ff[31] & run_ff[31], 31'd0};
            end else if (tk == K_ZERO) begin
               res_in = run_ff;
            end else if (rk == K_ZERO) begin
               res_in = term_ff;
            end else begin
               if (term_ff[30:0] > run_ff[30:0]) begin
                  a = term_ff;
                  b = run_ff;
               end else begin
                  a = run_ff;
                  b = term_ff;
               end
               sign_in = a[31];
               exp_in  = {1'b0, a[30:23]};
               sub_in  = a[31] ^ b[31];
               siga_in = {1'b1, a[22:0], 3'd0};
               eb      = {1'b1, b[22:0], 3'd0};
               d       = a[30:23] - b[30:23];
               if (d >= 8'd27) begin
                  sigb_in = 27'd1;
               end else begin
                  sh      = eb >> d;
                  mask    = (27'd1 << d) - 27'd1;
                  sigb_in = sh | 27'((eb & mask) != 27'd0);
               end
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            sum_in   = sub_ff ? {1'b0, siga_ff} - {1'b0, sigb_ff}
                              : {1'b0, siga_ff} + {1'b0, sigb_ff};
            state_in = S_NORM;
         end
         S_NORM: begin
            zero_in = sum_ff == 28'd0;
            if (sum_ff[27]) begin
               norm_in = {sum_ff[27:2], sum_ff[1] | sum_ff[0]};
               exp_in  = exp_ff + 9'd1;
            end else begin
               lz      = lzc27(sum_ff[26:0]);
               norm_in = sum_ff[26:0] << lz;
               exp_in  = exp_ff - {4'd0, lz};
            end
            state_in = S_RND;
         end
         S_RND: begin
            res_in   = zero_ff ? 32'd0 : round_pack(sign_ff, exp_ff, norm_ff);
            state_in = S_DONE;
         end
         S_DONE: begin
            if (ent_ff.last) begin
               if (!rv_ff || rsp_tready) begin
                  emit     = 1'b1;
                  rv_in    = 1'b1;
                  rd_in    = res_ff;
                  run_in   = 32'd0;
                  state_in = S_IDLE;
               end
            end else begin
               run_in   = res_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         run_ff   <= 32'd0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         run_ff   <= run_in;
         rv_ff    <= rv_in;
      end
      ent_ff  <= ent_in;
      prod_ff <= prod_in;
      norm_ff <= norm_in;
      siga_ff <= siga_in;
      sigb_ff <= sigb_in;
      sum_ff  <= sum_in;
      exp_ff  <= exp_in;
      sign_ff <= sign_in;
      sub_ff  <= sub_in;
      zero_ff <= zero_in;
      kind_ff <= kind_in;
      term_ff <= term_in;
      res_ff  <= res_in;
      rd_ff   <= rd_in;
   end

endmodule

[rtl/q4_block_dot_row_accumulator_unit.sv]
// The back-end float sequencer takes one block at a time and only when idle; if term or running
// sum is 0/Inf/NaN it skips the add, normalise and round states. The front pipeline, 4-entry
// queue and back end take up to 7 beats before stalling.
// Reset (synchronous, active high) empties the pipeline and queue, drops any pending
// result and sets the running sum to +0.0.
`include "q4_block_dot_row_accumulator_unit_macros.svh"

module q4_block_dot_row_accumulator_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // scale_half, weight_bytes_low, weight_bytes_high, act_word_0..act_word_3
   input  logic [399:0] req_tdata,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // row_sum
   output logic [31:0]  rsp_tdata
);

   logic                q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
   q4bd_pkg::qent_type  q_push_data, q_pop_data;
   q4bd_pkg::bstat_type bstat;

   q4bd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (q_push_valid),
      .push_data  (q_push_data),
      .push_ready (q_push_ready)
   );

   q4bd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_data  (q_push_data),
      .push_ready (q_push_ready),
      .pop_valid  (q_pop_valid),
      .pop_data   (q_pop_data),
      .pop_ready  (q_pop_ready)
   );

   q4bd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (q_pop_valid),
      .pop_data   (q_pop_data),
      .pop_ready  (q_pop_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .status     (bstat)
   );

   `Q4BD_ASSERT_NOW(a_pop_only_idle, q_pop_valid && q_pop_ready, bstat.idle, "pop while busy")
   `Q4BD_ASSERT_NOW(a_no_overwrite, bstat.emit, !rsp_tvalid || rsp_tready, "result overwritten")
   `Q4BD_ASSERT_NEXT(a_emit_shows, bstat.emit, rsp_tvalid, "emitted result not shown")

endmodule

[tb/sv/q4_row_sum_checker.sv]
module q4_row_sum_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [399:0] req_tdata,
   input  logic         req_tlast,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [31:0]  rsp_tdata,
   output int           fail_count,
   output int           pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [31:0] QNAN = 32'h7FC0_0000;

   logic [31:0] row_acc;
   logic [31:0] row_sums_due[$];

   assign pending = row_sums_due.size();

   function automatic bit is_nan(logic [31:0] f);
      return f[30:23] == 8'hFF && f[22:0] != 0;
   endfunction

   function automatic bit is_inf(logic [31:0] f);
      return f[30:23] == 8'hFF && f[22:0] == 0;
   endfunction

   // round sign * mag * 2^e to single, nearest even
   function automatic logic [31:0] round_single(bit sgn, logic [329:0] mag, int e);
      int p, lsbexp, sh;
      logic [329:0] m, rem, halfway;
      if (mag == 0) return {sgn, 31'b0};
      p = 0;
      for (int i = 0; i < 330; i++) if (mag[i]) p = i;
      lsbexp = p + e - 23;
      if (lsbexp < -149) lsbexp = -149;
      sh = lsbexp - e;
      if (sh <= 0) begin
         m = mag << (-sh);
      end else begin
         m = mag >> sh;
         rem = mag & ((330'b1 << sh) - 1);
         halfway = 330'b1 << (sh - 1);
         if (rem > halfway || (rem == halfway && m[0])) m = m + 1;
      end
      if (m[24]) begin
         m = m >> 1;
         lsbexp++;
      end
      if (m[23]) begin
         if (lsbexp + 150 >= 255) return {sgn, 8'hFF, 23'b0};
         return {sgn, 8'(lsbexp + 150), m[22:0]};
      end
      return {sgn, 8'b0, m[22:0]};
   endfunction

   function automatic void split(input logic [31:0] f, output logic [23:0] m,
                                 output int e);
      if (f[30:23] == 0) begin
         m = {1'b0, f[22:0]};
         e = -149;
      end else begin
         m = {1'b1, f[22:0]};
         e = int'(f[30:23]) - 150;
      end
   endfunction

   function automatic logic [31:0] widen_half(logic [15:0] h);
      logic [31:0] sgn;
      logic [9:0]  man;
      int          ex;
      sgn = {h[15], 31'b0};
      man = h[9:0];
      if (h[14:10] == 0) begin
         if (man == 0) return sgn;
         ex = 1;
         while (man[9] == 0) begin
            man = man << 1;
            ex--;
         end
         man = man << 1;
         ex--;
         // leading one now shifted out
         return sgn | (32'(ex + 112) << 23) | ({22'b0, man} << 13);
      end
      if (h[14:10] == 5'h1F) return sgn | 32'h7F80_0000 | ({22'b0, h[9:0]} << 13);
      return sgn | (32'(h[14:10] + 112) << 23) | ({22'b0, h[9:0]} << 13);
   endfunction

   function automatic logic [31:0] scale_by_dot(logic [31:0] a, int dot);
      logic [23:0] m;
      int          e;
      bit          sgn;
      if (is_nan(a)) return QNAN;
      sgn = a[31] ^ (dot < 0);
      if (is_inf(a)) return (dot == 0) ? QNAN : {sgn, 8'hFF, 23'b0};
      split(a, m, e);
      return round_single(sgn, 330'(m) * 330'(dot < 0 ? -dot : dot), e);
   endfunction

   function automatic logic [31:0] div64(logic [31:0] a);
      logic [23:0] m;
      int          e;
      if (is_nan(a)) return QNAN;
      if (is_inf(a)) return a;
      split(a, m, e);
      return round_single(a[31], 330'(m), e - 6);
   endfunction

   function automatic logic [31:0] add_single(logic [31:0] a, logic [31:0] b);
      logic [23:0]  ma, mb;
      int           ea, eb, emin;
      logic [329:0] wa, wb, s;
      bit           sgn;
      if (is_nan(a) || is_nan(b)) return QNAN;
      if (is_inf(a) && is_inf(b)) return (a[31] != b[31]) ? QNAN : a;
      if (is_inf(a)) return a;
      if (is_inf(b)) return b;
      split(a, ma, ea);
      split(b, mb, eb);
      if (ma == 0 && mb == 0) return {a[31] & b[31], 31'b0};
      emin = (ea < eb) ? ea : eb;
      wa = 330'(ma) << (ea - emin);
      wb = 330'(mb) << (eb - emin);
      if (a[31] == b[31]) begin
         s = wa + wb;
         sgn = a[31];
      end else if (wa >= wb) begin
         s = wa - wb;
         sgn = a[31];
      end else begin
         s = wb - wa;
         sgn = b[31];
      end
      if (s == 0) return 32'b0;
      return round_single(sgn, s, emin);
   endfunction

   function automatic int block_dot(logic [399:0] d);
      int          acc;
      logic [7:0]  wb;
      logic [7:0]  a_lo, a_hi;
      acc = 0;
      for (int j = 0; j < 16; j++) begin
         wb = d[16 + 8*j +: 8];
         a_lo = d[144 + 16*j +: 8];
         a_hi = d[152 + 16*j +: 8];
         acc += (int'(wb[3:0]) - 8) * int'($signed(a_lo));
         acc += (int'(wb[7:4]) - 8) * int'($signed(a_hi));
      end
      return acc;
   endfunction

   always @(posedge clock) begin
      logic [31:0] term;
      if (reset) begin
         row_acc <= 32'b0;
         row_sums_due.delete();
         fail_count <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            term = div64(scale_by_dot(widen_half(req_tdata[15:0]), block_dot(req_tdata)));
            term = add_single(row_acc, term);
            if (is_nan(term)) term = QNAN;
            if (req_tlast) begin
               row_sums_due.push_back(term);
               row_acc <= 32'b0;
            end else begin
               row_acc <= term;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (row_sums_due.size() == 0) begin
               $display("%0t: unexpected row sum beat, actual %h", $time, rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               if (rsp_tdata !== row_sums_due[0]) begin
                  $display("%0t: row_sum mismatch, expected %h, actual %h",
                           $time, row_sums_due[0], rsp_tdata);
                  fail_count <= fail_count + 1;
               end
               void'(row_sums_due.pop_front());
            end
         end
      end
   end

endmodule

[tb/sv/tb_q4_block_dot_row_accumulator_unit.sv]
module tb_q4_block_dot_row_accumulator_unit;
   timeunit 1ns;
   timeprecision 1ps;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [399:0] req_tdata = '0;
   logic         req_tlast = 0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [31:0]  rsp_tdata;
   int           fail_count, pending;
   int           cycles = 0;
   bit           calm = 0;
   bit           hold_off = 0;

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   q4_block_dot_row_accumulator_unit dut (.*);

   q4_row_sum_checker chk (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("q4_block_dot_row_accumulator_unit verification failed");
         $finish;
      end
   end

   // result side: random stall bursts, one long hold-off on request
   initial begin
      int n;
      @(negedge reset);
      forever begin
         if (hold_off) begin
            rsp_tready <= 0;
            repeat (300) @(posedge clock);
            hold_off = 0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 6);
            rsp_tready <= 0;
            repeat (n) @(posedge clock);
         end else begin
            rsp_tready <= 1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   task automatic send_block(logic [15:0] sc, logic [127:0] w, logic [255:0] act, bit last);
      req_tvalid <= 1;
      req_tdata <= {act, w, sc};
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   function automatic logic [127:0] rand128();
      return {$urandom, $urandom, $urandom, $urandom};
   endfunction

   function automatic logic [15:0] rand_scale();
      int k;
      k = $urandom_range(0, 99);
      if (k < 2) return {$urandom_range(0, 1) == 1, 5'h1F, 10'($urandom)};
      if (k < 6) return {$urandom_range(0, 1) == 1, 5'h00, 10'($urandom)};
      if (k < 15) return 16'($urandom);
      return {$urandom_range(0, 1) == 1, 5'($urandom_range(8, 22)), 10'($urandom)};
   endfunction

   initial begin
      logic [15:0] dir_scales[12] = '{16'h0000, 16'h8000, 16'h0001, 16'h03FF,
         16'h7BFF, 16'hFBFF, 16'h3C00, 16'h7C00, 16'hFC00, 16'h7E00, 16'h7C01, 16'h0400};
      int rows, len;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: scale extremes and specials, nibble and activation extremes
      foreach (dir_scales[i]) begin
         send_block(dir_scales[i], {16{8'h0F}}, {32{8'h80}}, 0);
         send_block(16'h3C00, {16{8'hF0}}, {32{8'h7F}}, 1);
      end
      send_block(16'h7C00, {16{8'h88}}, rand128() | {rand128(), 128'b0}, 1);
      send_block(16'hFC00, {16{8'hFF}}, {32{8'h80}}, 0);
      send_block(16'h7C00, {16{8'h00}}, {32{8'h80}}, 1);
      send_block(16'h7BFF, {16{8'h00}}, {32{8'h80}}, 1);
      // random rows
      rows = 0;
      for (int n = 0; n < 1920; ) begin
         len = $urandom_range(1, 8);
         if (n > 1700) calm = 1;
         if (rows == 40) hold_off = 1;
         if (rows == 80) begin
            req_tvalid <= 0;
            @(posedge clock);
            while (pending != 0) @(posedge clock);
         end
         for (int b = 0; b < len; b++)
            send_block(rand_scale(), rand128(), {rand128(), rand128()}, b == len - 1);
         n += len;
         rows++;
      end
      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0) $display("q4_block_dot_row_accumulator_unit verification clean");
      else $display("q4_block_dot_row_accumulator_unit verification failed");
      $finish;
   end

endmodule
